### hdl/prc_pkg.sv
// Shared types, constants and match functions for the packet rule classifier.
`default_nettype none

package prc_pkg;

    localparam int RULES    = 16;
    localparam int ANY_TYPE = 65535;

    localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CMP_W = (IDX_W > 4) ? IDX_W : 4;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CMP_W-1:0] cmp_t;

    localparam logic       CMD_WRITE    = 1'b0;
    localparam logic       CMD_CLASSIFY = 1'b1;

    localparam logic [1:0] SEL_SRC   = 2'd0;
    localparam logic [1:0] SEL_DST   = 2'd1;
    localparam logic [1:0] SEL_PORT  = 2'd2;
    localparam logic [1:0] SEL_FLAGS = 2'd3;

    localparam logic [1:0] PROTO_TCP  = 2'd0;
    localparam logic [1:0] PROTO_UDP  = 2'd1;
    localparam logic [1:0] PROTO_ICMP = 2'd2;
    localparam logic [1:0] PROTO_NONE = 2'd3;

    localparam int FLG_SRC_NEG   = 0;
    localparam int FLG_DST_NEG   = 1;
    localparam int FLG_SPORT_NEG = 2;
    localparam int FLG_DPORT_NEG = 3;
    localparam int FLG_IGNORE    = 4;
    localparam int FLG_PROTO_LO  = 5;
    localparam int FLG_VALID     = 7;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  rule_index;
        logic [1:0]  word_select;
        logic [63:0] word_data;
        logic [1:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } item_t;

    typedef struct packed {
        logic       matched;
        logic       ignore;
        logic [3:0] hit_index;
    } verdict_t;

    typedef struct packed {
        logic     valid;
        item_t    item;
        verdict_t verdict;
    } stage_t;

    function automatic logic addr_covers(logic [63:0] word, logic [31:0] host);
        logic [31:0] a;
        logic [31:0] m;
        a = word[31:0];
        m = word[63:32];
        return (a == '0) || (host == '0) || (a == host) || (((host ^ a) & m) == '0);
    endfunction

    function automatic logic range_match(logic [15:0] lo, logic [15:0] hi, logic [15:0] p);
        logic r;
        if (lo == '0 && hi == '0)
        begin
            r = 1'b1;
        end
        else if (lo == hi)
        begin
            r = (p == lo);
        end
        else if (hi == '0)
        begin
            r = (p >= lo);
        end
        else if (lo == '0)
        begin
            r = (p <= hi);
        end
        else
        begin
            r = (p >= lo) && (p <= hi);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/prc_ifs.sv
// Request and response channel interfaces of the packet rule classifier.
`default_nettype none

interface prc_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [3:0]  rule_index;
    logic [1:0]  word_select;
    logic [63:0] word_data;
    logic [1:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;

    modport source (
        output valid, cmd, rule_index, word_select, word_data, protocol,
               src_addr, dst_addr, src_port, dst_port,
        input  ready
    );
    modport sink (
        input  valid, cmd, rule_index, word_select, word_data, protocol,
               src_addr, dst_addr, src_port, dst_port,
        output ready
    );
endinterface

interface prc_rsp_if;
    logic       valid;
    logic       ready;
    logic       ignore;
    logic       matched;
    logic [3:0] hit_index;

    modport source (
        output valid, ignore, matched, hit_index,
        input  ready
    );
    modport sink (
        input  valid, ignore, matched, hit_index,
        output ready
    );
endinterface

`default_nettype wire

### hdl/prc_cell.sv
// One rule cell: holds a rule, applies writes addressed to it, and checks passing headers.
`default_nettype none

module prc_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire prc_pkg::idx_t   cell_id,
    input  wire prc_pkg::stage_t stage_in,
    output prc_pkg::stage_t      stage_out
);

    logic [63:0] src_word_reg;
    logic [63:0] dst_word_reg;
    logic [63:0] port_word_reg;
    logic [7:0]  flags_reg;
    logic        valid_reg;
    prc_pkg::item_t    item_reg;
    prc_pkg::verdict_t verdict_reg;
    prc_pkg::verdict_t verdict_next;

    logic        wr_hit;
    logic        rule_on;
    logic        src_ok;
    logic        dst_ok;
    logic        dport_ok;
    logic        sport_ok;
    logic        type_ok;
    logic        rule_ok;
    logic [15:0] icmp_type;

    assign wr_hit = stage_in.valid && (stage_in.item.cmd == prc_pkg::CMD_WRITE)
                 && (prc_pkg::cmp_t'(stage_in.item.rule_index) == prc_pkg::cmp_t'(cell_id));

    assign icmp_type = port_word_reg[47:32];

    always_comb
    begin
        rule_on  = flags_reg[prc_pkg::FLG_VALID]
                && (flags_reg[prc_pkg::FLG_PROTO_LO +: 2] == stage_in.item.protocol)
                && (stage_in.item.protocol != prc_pkg::PROTO_NONE)
                && (stage_in.item.cmd == prc_pkg::CMD_CLASSIFY)
                && !stage_in.verdict.matched;
        src_ok   = prc_pkg::addr_covers(src_word_reg, stage_in.item.src_addr)
                 ^ flags_reg[prc_pkg::FLG_SRC_NEG];
        dst_ok   = prc_pkg::addr_covers(dst_word_reg, stage_in.item.dst_addr)
                 ^ flags_reg[prc_pkg::FLG_DST_NEG];
        dport_ok = prc_pkg::range_match(port_word_reg[47:32], port_word_reg[63:48],
                                        stage_in.item.dst_port)
                 ^ flags_reg[prc_pkg::FLG_DPORT_NEG];
        sport_ok = prc_pkg::range_match(port_word_reg[15:0], port_word_reg[31:16],
                                        stage_in.item.src_port)
                 ^ flags_reg[prc_pkg::FLG_SPORT_NEG];
        type_ok  = ((icmp_type == 16'(prc_pkg::ANY_TYPE))
                   || (icmp_type == stage_in.item.dst_port))
                 ^ flags_reg[prc_pkg::FLG_DPORT_NEG];
        if (stage_in.item.protocol == prc_pkg::PROTO_ICMP)
        begin
            rule_ok = src_ok && dst_ok && type_ok;
        end
        else
        begin
            rule_ok = src_ok && dst_ok && dport_ok && sport_ok;
        end

        verdict_next = stage_in.verdict;
        if (rule_on && rule_ok)
        begin
            verdict_next.matched   = 1'b1;
            verdict_next.ignore    = flags_reg[prc_pkg::FLG_IGNORE];
            verdict_next.hit_index = 4'(cell_id);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= stage_in.valid;
            if (wr_hit && stage_in.item.word_select == prc_pkg::SEL_FLAGS)
            begin
                flags_reg <= stage_in.item.word_data[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg    <= stage_in.item;
            verdict_reg <= verdict_next;
            if (wr_hit)
            begin
                unique case (stage_in.item.word_select)
                    prc_pkg::SEL_SRC:   src_word_reg  <= stage_in.item.word_data;
                    prc_pkg::SEL_DST:   dst_word_reg  <= stage_in.item.word_data;
                    prc_pkg::SEL_PORT:  port_word_reg <= stage_in.item.word_data;
                    prc_pkg::SEL_FLAGS: ;
                    default:            ;
                endcase
            end
        end
    end

    assign stage_out.valid   = valid_reg;
    assign stage_out.item    = item_reg;
    assign stage_out.verdict = verdict_reg;

endmodule

`default_nettype wire

### hdl/packet_rule_classifier.sv
// Top level: entry stage, chain of rule cells, and output register.
// Each request is registered in every rule cell and then in the output register.
// One transfer per cycle unless stalled; writes and headers pass the cells in order.
// The whole chain stalls only while the output register holds an untaken response.
// Reset clears all valid bits and every rule's flags, so no rule is active.
// Address and port words of a rule are not reset.
`default_nettype none

module packet_rule_classifier (
    input  wire logic clk,
    input  wire logic rst_n,
    prc_req_if.sink   req,
    prc_rsp_if.source rsp
);

    prc_pkg::stage_t   chain [0:prc_pkg::RULES];
    logic              advance;
    logic              out_valid_reg;
    prc_pkg::verdict_t out_verdict_reg;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = advance;

    always_comb
    begin
        chain[0].valid            = req.valid;
        chain[0].item.cmd         = req.cmd;
        chain[0].item.rule_index  = req.rule_index;
        chain[0].item.word_select = req.word_select;
        chain[0].item.word_data   = req.word_data;
        chain[0].item.protocol    = req.protocol;
        chain[0].item.src_addr    = req.src_addr;
        chain[0].item.dst_addr    = req.dst_addr;
        chain[0].item.src_port    = req.src_port;
        chain[0].item.dst_port    = req.dst_port;
        chain[0].verdict          = '0;
    end

    for (genvar i = 0; i < prc_pkg::RULES; i++)
    begin : g_cell
        prc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .cell_id   (prc_pkg::idx_t'(i)),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain[prc_pkg::RULES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_verdict_reg <= chain[prc_pkg::RULES].verdict;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.ignore    = out_verdict_reg.ignore;
    assign rsp.matched   = out_verdict_reg.matched;
    assign rsp.hit_index = out_verdict_reg.hit_index;

endmodule

`default_nettype wire

### hdl/prc_checker.sv
// Port-level assertions for the packet rule classifier, bound to the top level.
`default_nettype none

module prc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic       rsp_ignore,
    input wire logic       rsp_matched,
    input wire logic [3:0] rsp_hit_index
);

    a_ignore_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ignore) |-> rsp_matched)
        else $error("ignore set without a match");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_matched) |-> (rsp_hit_index == 4'd0))
        else $error("hit index nonzero on a miss");

    a_hit_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_matched) |-> (32'(rsp_hit_index) < prc_pkg::RULES))
        else $error("hit index beyond rule table");

    a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (rsp_valid && !rsp_ready))
        else $error("request stalled without output backpressure");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_matched)
                                       && $stable(rsp_ignore) && $stable(rsp_hit_index)))
        else $error("response changed while stalled");

endmodule

bind packet_rule_classifier prc_checker u_prc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_ignore    (rsp.ignore),
    .rsp_matched   (rsp.matched),
    .rsp_hit_index (rsp.hit_index)
);

`default_nettype wire

### dv/packet_rule_classifier_tb.sv
// Self-checking testbench for packet_rule_classifier: rule loads and header classification.
`timescale 1ns / 100ps

module packet_rule_classifier_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    prc_req_if req_ch ();
    prc_rsp_if rsp_ch ();

    packet_rule_classifier u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow rule table, updated at each write request transfer
    logic [63:0] src_tbl [prc_pkg::RULES];
    logic [63:0] dst_tbl [prc_pkg::RULES];
    logic [63:0] port_tbl [prc_pkg::RULES];
    logic [7:0]  flag_tbl [prc_pkg::RULES];
    logic [2:0]  words_seen [prc_pkg::RULES];

    prc_pkg::verdict_t expected_verdicts [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    logic [31:0] addr_pool [4];

    initial
    begin
        for (int i = 0; i < prc_pkg::RULES; i++)
        begin
            src_tbl[i] = '0;
            dst_tbl[i] = '0;
            port_tbl[i] = '0;
            flag_tbl[i] = '0;
            words_seen[i] = '0;
        end
    end

    function automatic logic addr_hit(input logic [63:0] word, input logic [31:0] host);
        if (word[31:0] == 32'd0 || host == 32'd0)
        begin
            return 1'b1;
        end
        return ((host ^ word[31:0]) & word[63:32]) == 32'd0;
    endfunction

    function automatic logic span_hit(input logic [15:0] lo, input logic [15:0] hi,
                                      input logic [15:0] p);
        if (lo == 16'd0 && hi == 16'd0)
        begin
            return 1'b1;
        end
        if (lo == hi)
        begin
            return p == lo;
        end
        return (lo == 16'd0 || p >= lo) && (hi == 16'd0 || p <= hi);
    endfunction

    // applies a rule write or finds the first matching rule for a header
    function automatic prc_pkg::verdict_t table_verdict(input prc_pkg::item_t it);
        prc_pkg::verdict_t v;
        logic [7:0]  f;
        logic [63:0] pw;
        logic        ok;
        logic        dm;
        logic        sm;
        v = '0;
        if (it.cmd == prc_pkg::CMD_WRITE)
        begin
            case (it.word_select)
                prc_pkg::SEL_SRC:
                begin
                    src_tbl[it.rule_index] = it.word_data;
                    words_seen[it.rule_index][0] = 1'b1;
                end
                prc_pkg::SEL_DST:
                begin
                    dst_tbl[it.rule_index] = it.word_data;
                    words_seen[it.rule_index][1] = 1'b1;
                end
                prc_pkg::SEL_PORT:
                begin
                    port_tbl[it.rule_index] = it.word_data;
                    words_seen[it.rule_index][2] = 1'b1;
                end
                default:
                begin
                    flag_tbl[it.rule_index] = it.word_data[7:0];
                end
            endcase
            return v;
        end
        if (it.protocol == prc_pkg::PROTO_NONE)
        begin
            return v;
        end
        for (int i = 0; i < prc_pkg::RULES; i++)
        begin
            f = flag_tbl[i];
            pw = port_tbl[i];
            if (f[prc_pkg::FLG_VALID] && f[prc_pkg::FLG_PROTO_LO +: 2] == it.protocol)
            begin
                ok = (addr_hit(src_tbl[i], it.src_addr) ^ f[prc_pkg::FLG_SRC_NEG])
                  && (addr_hit(dst_tbl[i], it.dst_addr) ^ f[prc_pkg::FLG_DST_NEG]);
                if (it.protocol == prc_pkg::PROTO_ICMP)
                begin
                    dm = (pw[47:32] == 16'(prc_pkg::ANY_TYPE)) || (pw[47:32] == it.dst_port);
                    ok = ok && (dm ^ f[prc_pkg::FLG_DPORT_NEG]);
                end
                else
                begin
                    dm = span_hit(pw[47:32], pw[63:48], it.dst_port);
                    sm = span_hit(pw[15:0], pw[31:16], it.src_port);
                    ok = ok && (dm ^ f[prc_pkg::FLG_DPORT_NEG])
                            && (sm ^ f[prc_pkg::FLG_SPORT_NEG]);
                end
                if (ok)
                begin
                    v.matched = 1'b1;
                    v.ignore = f[prc_pkg::FLG_IGNORE];
                    v.hit_index = 4'(i);
                    return v;
                end
            end
        end
        return v;
    endfunction

    // predict on request transfer, check on response transfer
    always @(posedge clk)
    begin : scoreboard
        prc_pkg::item_t    acc;
        prc_pkg::verdict_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                acc.cmd = req_ch.cmd;
                acc.rule_index = req_ch.rule_index;
                acc.word_select = req_ch.word_select;
                acc.word_data = req_ch.word_data;
                acc.protocol = req_ch.protocol;
                acc.src_addr = req_ch.src_addr;
                acc.dst_addr = req_ch.dst_addr;
                acc.src_port = req_ch.src_port;
                acc.dst_port = req_ch.dst_port;
                expected_verdicts.push_back(table_verdict(acc));
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: unexpected response: ignore=%0b matched=%0b hit=%0d",
                                 $realtime, rsp_ch.ignore, rsp_ch.matched, rsp_ch.hit_index);
                    end
                    mismatches++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (rsp_ch.ignore !== want.ignore || rsp_ch.matched !== want.matched
                        || rsp_ch.hit_index !== want.hit_index)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: mismatch exp i=%0b m=%0b h=%0d got i=%0b m=%0b h=%0d",
                                     $realtime, want.ignore, want.matched, want.hit_index,
                                     rsp_ch.ignore, rsp_ch.matched, rsp_ch.hit_index);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("packet_rule_classifier_tb: errors");
            $finish;
        end
    end

    // response back-pressure: segments of no stall, rotating pattern, or coin flips
    initial
    begin : rsp_stalls
        logic [15:0] pat;
        int          mode;
        int          seg_left;
        rsp_ch.ready = 1'b0;
        pat = 16'hFFFF;
        mode = 0;
        seg_left = 0;
        forever
        begin
            @(posedge clk);
            if (seg_left == 0)
            begin
                mode = $urandom_range(0, 2);
                pat = 16'($urandom) | 16'h0001;
                seg_left = $urandom_range(50, 300);
            end
            seg_left--;
            pat = {pat[14:0], pat[15]};
            case (mode)
                0:
                begin
                    rsp_ch.ready <= 1'b1;
                end
                1:
                begin
                    rsp_ch.ready <= pat[15];
                end
                default:
                begin
                    rsp_ch.ready <= 1'($urandom);
                end
            endcase
        end
    end

    function automatic prc_pkg::item_t random_item();
        prc_pkg::item_t it;
        it.cmd = 1'($urandom);
        it.rule_index = 4'($urandom);
        it.word_select = 2'($urandom);
        it.word_data = {$urandom, $urandom};
        it.protocol = 2'($urandom);
        it.src_addr = $urandom;
        it.dst_addr = $urandom;
        it.src_port = 16'($urandom);
        it.dst_port = 16'($urandom);
        return it;
    endfunction

    // one transfer; the sender idles between bursts of random length
    task automatic send_item(input prc_pkg::item_t it);
        int gap;
        req_ch.valid <= 1'b1;
        req_ch.cmd <= it.cmd;
        req_ch.rule_index <= it.rule_index;
        req_ch.word_select <= it.word_select;
        req_ch.word_data <= it.word_data;
        req_ch.protocol <= it.protocol;
        req_ch.src_addr <= it.src_addr;
        req_ch.dst_addr <= it.dst_addr;
        req_ch.src_port <= it.src_port;
        req_ch.dst_port <= it.dst_port;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 12);
        end
    endtask

    task automatic load_rule(input logic [3:0] idx, input logic [63:0] src_w,
                             input logic [63:0] dst_w, input logic [63:0] port_w,
                             input logic [7:0] flags);
        prc_pkg::item_t it;
        it = random_item();
        it.cmd = prc_pkg::CMD_WRITE;
        it.rule_index = idx;
        it.word_select = prc_pkg::SEL_SRC;
        it.word_data = src_w;
        send_item(it);
        it.word_select = prc_pkg::SEL_DST;
        it.word_data = dst_w;
        send_item(it);
        it.word_select = prc_pkg::SEL_PORT;
        it.word_data = port_w;
        send_item(it);
        it.word_select = prc_pkg::SEL_FLAGS;
        it.word_data = {$urandom, 24'($urandom), flags};
        send_item(it);
    endtask

    task automatic send_header(input logic [1:0] proto, input logic [31:0] sa,
                               input logic [31:0] da, input logic [15:0] sp,
                               input logic [15:0] dp);
        prc_pkg::item_t it;
        it = random_item();
        it.cmd = prc_pkg::CMD_CLASSIFY;
        it.protocol = proto;
        it.src_addr = sa;
        it.dst_addr = da;
        it.src_port = sp;
        it.dst_port = dp;
        send_item(it);
    endtask

    task automatic test_empty_table();
        send_header(prc_pkg::PROTO_TCP, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80);
        send_header(prc_pkg::PROTO_ICMP, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'd8);
    endtask

    task automatic test_tcp_udp_ports();
        // exact dport 80 from 10.0.0.0/24, then a catch-all ignore rule at the bottom
        load_rule(4'd0, {32'hFFFFFF00, 32'h0A000000}, 64'd0,
                  {16'd80, 16'd80, 16'd0, 16'd0},
                  {1'b1, prc_pkg::PROTO_TCP, 1'b0, 4'b0000});
        load_rule(4'd15, 64'd0, 64'd0, 64'd0, {1'b1, prc_pkg::PROTO_TCP, 1'b1, 4'b0000});
        send_header(prc_pkg::PROTO_TCP, 32'h0A000007, 32'hFFFFFFFF, 16'hFFFF, 16'd80);
        send_header(prc_pkg::PROTO_TCP, 32'h0A000107, 32'h00000000, 16'h0000, 16'd80);
        // open-ended dport, inverted sport bounds, negated source/sport/dport
        load_rule(4'd1, {32'hFFFFFFFF, 32'hC0A80001}, {32'h0, 32'hFFFFFFFF},
                  {16'd0, 16'd1024, 16'd100, 16'd200},
                  {1'b1, prc_pkg::PROTO_UDP, 1'b1, 4'b1101});
        send_header(prc_pkg::PROTO_UDP, 32'hC0A80002, 32'h12345678, 16'd150, 16'd80);
        send_header(prc_pkg::PROTO_UDP, 32'hC0A80001, 32'h12345678, 16'd150, 16'hFFFF);
    endtask

    task automatic test_icmp_types();
        load_rule(4'd2, 64'd0, {32'hFFFF0000, 32'h08080000},
                  {16'hFFFF, 16'd8, 32'h0}, {1'b1, prc_pkg::PROTO_ICMP, 1'b0, 4'b1000});
        load_rule(4'd3, {32'hFFFFFFFF, 32'hFFFFFFFF}, 64'd0,
                  {16'h0, 16'(prc_pkg::ANY_TYPE), 32'hFFFFFFFF},
                  {1'b1, prc_pkg::PROTO_ICMP, 1'b1, 4'b0000});
        send_header(prc_pkg::PROTO_ICMP, 32'h01020304, 32'h08080101, 16'd0, 16'd8);
        send_header(prc_pkg::PROTO_ICMP, 32'h01020304, 32'h08080101, 16'd0, 16'd0);
        send_header(prc_pkg::PROTO_ICMP, 32'hFFFFFFFF, 32'h09090909, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_protocol_three();
        prc_pkg::item_t it;
        send_header(prc_pkg::PROTO_NONE, 32'h0A000007, 32'h0, 16'd0, 16'd80);
        it = random_item();
        it.cmd = prc_pkg::CMD_WRITE;
        it.rule_index = 4'd15;
        it.word_select = prc_pkg::SEL_FLAGS;
        it.word_data[7:0] = {1'b1, prc_pkg::PROTO_NONE, 1'b1, 4'b0000};
        send_item(it);
        send_header(prc_pkg::PROTO_TCP, 32'h0A000107, 32'h0, 16'd0, 16'd80);
    endtask

    function automatic logic [63:0] random_addr_word();
        logic [31:0] a;
        logic [31:0] m;
        int          len;
        len = $urandom_range(0, 32);
        m = (len == 0) ? 32'h0 : ~(32'hFFFFFFFF >> len);
        if ($urandom_range(0, 4) == 0)
        begin
            m = $urandom;
        end
        case ($urandom_range(0, 5))
            0: a = 32'h0;
            1: a = $urandom;
            default: a = addr_pool[$urandom_range(0, 3)];
        endcase
        return {m, a};
    endfunction

    function automatic logic [15:0] random_bound();
        case ($urandom_range(0, 5))
            0, 1: return 16'h0;
            2: return 16'hFFFF;
            3: return 16'($urandom);
            default: return 16'($urandom_range(1, 2048));
        endcase
    endfunction

    function automatic logic [63:0] random_port_word(input logic icmp);
        logic [15:0] smin, smax, dmin, dmax;
        smin = random_bound();
        smax = ($urandom_range(0, 4) == 0) ? smin : random_bound();
        dmin = random_bound();
        dmax = ($urandom_range(0, 4) == 0) ? dmin : random_bound();
        if (icmp && $urandom_range(0, 2) != 0)
        begin
            dmin = ($urandom_range(0, 2) == 0) ? 16'(prc_pkg::ANY_TYPE)
                                               : 16'($urandom_range(0, 18));
        end
        return {dmax, dmin, smax, smin};
    endfunction

    function automatic logic [31:0] near_addr(input logic [63:0] word);
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return $urandom;
            2: return word[31:0];
            3: return word[31:0] ^ (32'h1 << $urandom_range(0, 31));
            default: return (word[31:0] & word[63:32]) | ($urandom & ~word[63:32]);
        endcase
    endfunction

    function automatic logic [15:0] near_port(input logic [15:0] lo, input logic [15:0] hi);
        case ($urandom_range(0, 8))
            0: return lo;
            1: return hi;
            2: return lo - 16'd1;
            3: return hi + 16'd1;
            4: return 16'h0;
            5: return 16'hFFFF;
            6: return 16'($urandom_range(0, 18));
            7: return (hi >= lo) ? lo + 16'($urandom_range(0, hi - lo)) : 16'($urandom);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_header();
        prc_pkg::item_t it;
        int          r;
        logic [63:0] pw;
        it = random_item();
        it.cmd = prc_pkg::CMD_CLASSIFY;
        if ($urandom_range(0, 4) != 0)
        begin
            // aim at one stored rule and land on or near its edges
            r = $urandom_range(0, prc_pkg::RULES - 1);
            pw = port_tbl[r];
            it.protocol = ($urandom_range(0, 9) == 0) ? 2'($urandom)
                                                      : flag_tbl[r][prc_pkg::FLG_PROTO_LO +: 2];
            it.src_addr = near_addr(src_tbl[r]);
            it.dst_addr = near_addr(dst_tbl[r]);
            it.src_port = near_port(pw[15:0], pw[31:16]);
            it.dst_port = near_port(pw[47:32], pw[63:48]);
        end
        send_item(it);
    endtask

    task automatic test_random_traffic(input int count);
        int             sent;
        int             pick;
        prc_pkg::item_t it;
        logic [7:0]     flags;
        for (int i = 0; i < 4; i++)
        begin
            addr_pool[i] = $urandom & 32'hFFFFFF00;
        end
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                flags = {1'($urandom_range(0, 9) != 0),
                         ($urandom_range(0, 19) == 0) ? prc_pkg::PROTO_NONE
                                                      : 2'($urandom_range(0, 2)),
                         1'($urandom),
                         1'($urandom_range(0, 5) == 0), 1'($urandom_range(0, 5) == 0),
                         1'($urandom_range(0, 5) == 0), 1'($urandom_range(0, 5) == 0)};
                load_rule(4'($urandom), random_addr_word(), random_addr_word(),
                          random_port_word(flags[prc_pkg::FLG_PROTO_LO +: 2]
                                           == prc_pkg::PROTO_ICMP), flags);
                sent += 4;
            end
            else if (pick < 15)
            begin
                // lone word write; a rule with missing words stays invalid
                it = random_item();
                it.cmd = prc_pkg::CMD_WRITE;
                if (it.word_select == prc_pkg::SEL_FLAGS
                    && words_seen[it.rule_index] != 3'b111)
                begin
                    it.word_data[prc_pkg::FLG_VALID] = 1'b0;
                end
                send_item(it);
                sent++;
            end
            else
            begin
                send_random_header();
                sent++;
            end
        end
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.cmd = prc_pkg::CMD_WRITE;
        req_ch.rule_index = '0;
        req_ch.word_select = prc_pkg::SEL_SRC;
        req_ch.word_data = '0;
        req_ch.protocol = prc_pkg::PROTO_TCP;
        req_ch.src_addr = '0;
        req_ch.dst_addr = '0;
        req_ch.src_port = '0;
        req_ch.dst_port = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_tcp_udp_ports();
        test_icmp_types();
        test_protocol_three();
        test_random_traffic(1200);

        req_ch.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (prc_pkg::RULES + 8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("packet_rule_classifier_tb: clean");
        end
        else
        begin
            $display("packet_rule_classifier_tb: errors");
        end
        $finish;
    end

endmodule

### files.f
hdl/prc_pkg.sv
hdl/prc_ifs.sv
hdl/prc_cell.sv
hdl/packet_rule_classifier.sv
hdl/prc_checker.sv
dv/packet_rule_classifier_tb.sv
